[src/stream_interval_ewma_table_defines.svh]
// Assertion macros for the stream interval average table.
// Used by the top level; relies on signals named clk and rst in the including module.
`ifndef STREAM_INTERVAL_EWMA_TABLE_DEFINES_SVH
`define STREAM_INTERVAL_EWMA_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define SIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define SIE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIE_ASSERT(lbl, prop, msg)
`define SIE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/sie_pkg.sv]
// Shared types and codes for the stream interval average table.
// No dependencies; imported by every module of the block.
`default_nettype none

package sie_pkg;

  // Default number of table entries.
  localparam int SIE_ENTRIES = 16;

  // Event commands.
  localparam logic [1:0] CMD_ARRIVAL    = 2'd0;
  localparam logic [1:0] CMD_COMPLETION = 2'd1;
  localparam logic [1:0] CMD_RELEASE    = 2'd2;
  localparam logic [1:0] CMD_NONE       = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RELEASED = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CALC,
    S_RESP
  } state_t;

  // Flags that travel with the search token along the cell row.
  typedef struct packed {
    logic hit;
    logic free_found;
  } scan_flags_t;

  // Write-back controls broadcast to the cells.
  typedef struct packed {
    logic ins;
    logic clr;
    logic upd;
  } wb_ctl_t;

endpackage

`default_nettype wire

[src/sie_cell.sv]
// One table entry of the stream interval average table, with its stage of the search row.
// Depends on sie_pkg.
`default_nettype none

module sie_cell
  import sie_pkg::*;
#(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        req_cmd,
  input  wire logic [15:0]       req_id,
  input  wire scan_flags_t       flags_in,
  input  wire logic [IDX_W-1:0]  hit_idx_in,
  input  wire logic [IDX_W-1:0]  free_idx_in,
  input  wire logic [62:0]       last_in,
  input  wire logic [63:0]       avg_in,
  output scan_flags_t            flags_out,
  output logic      [IDX_W-1:0]  hit_idx_out,
  output logic      [IDX_W-1:0]  free_idx_out,
  output logic      [62:0]       last_out,
  output logic      [63:0]       avg_out,
  input  wire wb_ctl_t           wb,
  input  wire logic [IDX_W-1:0]  wb_idx,
  input  wire logic [15:0]       wb_id,
  input  wire logic [62:0]       wb_time,
  input  wire logic [63:0]       wb_avg
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic        valid;
  logic [15:0] stream;
  logic [62:0] arr_time;
  logic [62:0] cmp_time;
  logic [63:0] arr_avg;
  logic [63:0] cmp_avg;

  logic match;
  logic is_free;
  logic sel;
  logic kind_cmp;

  assign match    = valid && (stream == req_id);
  assign is_free  = !valid && !flags_in.free_found;
  assign sel      = (wb_idx == MY_IDX);
  assign kind_cmp = (req_cmd == CMD_COMPLETION);

  // Search stage: mark a hit or the first free entry and pass the token on.
  always_ff @(posedge clk) begin
    flags_out.hit        <= flags_in.hit | match;
    flags_out.free_found <= flags_in.free_found | !valid;
    hit_idx_out          <= match ? MY_IDX : hit_idx_in;
    free_idx_out         <= is_free ? MY_IDX : free_idx_in;
    if (match) begin
      last_out <= kind_cmp ? cmp_time : arr_time;
      avg_out  <= kind_cmp ? cmp_avg : arr_avg;
    end else begin
      last_out <= last_in;
      avg_out  <= avg_in;
    end
  end

  // Entry valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && wb.ins) begin
      valid <= 1'b1;
    end else if (sel && wb.clr) begin
      valid <= 1'b0;
    end
  end

  // Entry payload: fresh insert or update of one event kind.
  always_ff @(posedge clk) begin
    if (sel && wb.ins) begin
      stream   <= wb_id;
      arr_time <= wb_time;
      cmp_time <= wb_time;
      arr_avg  <= '0;
      cmp_avg  <= '0;
    end else if (sel && wb.upd) begin
      if (kind_cmp) begin
        cmp_time <= wb_time;
        cmp_avg  <= wb_avg;
      end else begin
        arr_time <= wb_time;
        arr_avg  <= wb_avg;
      end
    end
  end

endmodule

`default_nettype wire

[src/sie_ewma.sv]
// Four-stage average update: interval, exact delta, truncated half, new average.
// Depends on sie_pkg.
`default_nettype none

module sie_ewma
  import sie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [62:0] ts,
  input  wire logic [62:0] last,
  input  wire logic [63:0] avg,
  output logic             done,
  output logic [63:0]      result
);

  logic [3:0]  stage_v;
  logic [63:0] interval;
  logic [63:0] avg1;
  logic [63:0] avg2;
  logic [63:0] avg3;
  logic [64:0] delta;
  logic [63:0] half;
  logic [64:0] rounded;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      stage_v <= {stage_v[2:0], start};
    end
  end

  // Adding one to a negative delta before the shift rounds toward zero.
  assign rounded = delta + {64'd0, delta[64]};

  // Datapath stages.
  always_ff @(posedge clk) begin
    interval <= {1'b0, ts} - {1'b0, last};
    avg1     <= avg;
    delta    <= {interval[63], interval} - {avg1[63], avg1};
    avg2     <= avg1;
    half     <= rounded[64:1];
    avg3     <= avg2;
    result   <= avg3 + half;
  end

  assign done = stage_v[3];

endmodule

`default_nettype wire

[src/stream_interval_ewma_table.sv]
// Per-stream table of average time between arrivals and between completions.
// Depends on sie_pkg, sie_cell, sie_ewma and the assertion macro header.
`default_nettype none
`include "stream_interval_ewma_table_defines.svh"

// The block handles one event at a time. An event is taken only while the block
// is idle; a search token then walks the row of TABLE_ENTRIES cells, one cell a
// cycle, to find the stream and the lowest free entry. A release, an insert or a
// dropped event then passes through the decide and response states; an update
// of a known stream adds the four-stage average unit between those two states.
// Command code three is taken while idle and yields no result. The result sits
// in an output register, so the next event is taken while it waits.
// Table contents need no clearing after reset: only valid bits are cleared.
module stream_interval_ewma_table
  import sie_pkg::*;
#(
  parameter int TABLE_ENTRIES = SIE_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] stream_id,
  input  wire logic [62:0] timestamp,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      average_interval,
  output logic [1:0]       status
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(TABLE_ENTRIES - 1);

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0] cnt;
  logic [1:0]       req_cmd;
  logic [15:0]      req_id;
  logic [62:0]      req_ts;
  logic [1:0]       res_status;
  logic [63:0]      res_avg;
  wb_ctl_t          res_wb;
  logic [IDX_W-1:0] res_idx;

  wb_ctl_t wb;
  logic    ew_start;
  logic    ew_done;
  logic [63:0] ew_result;
  logic    slot_free;
  logic    is_event;

  scan_flags_t      flags_c [0:TABLE_ENTRIES];
  logic [IDX_W-1:0] hit_c   [0:TABLE_ENTRIES];
  logic [IDX_W-1:0] free_c  [0:TABLE_ENTRIES];
  logic [62:0]      last_c  [0:TABLE_ENTRIES];
  logic [63:0]      avg_c   [0:TABLE_ENTRIES];

  assign slot_free = !out_valid || !out_stall;
  assign is_event  = (req_cmd == CMD_ARRIVAL) || (req_cmd == CMD_COMPLETION);

  // Empty token enters the first cell.
  assign flags_c[0] = '0;
  assign hit_c[0]   = '0;
  assign free_c[0]  = '0;
  assign last_c[0]  = '0;
  assign avg_c[0]   = '0;

  // Row of table cells.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    sie_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .req_cmd      (req_cmd),
      .req_id       (req_id),
      .flags_in     (flags_c[i]),
      .hit_idx_in   (hit_c[i]),
      .free_idx_in  (free_c[i]),
      .last_in      (last_c[i]),
      .avg_in       (avg_c[i]),
      .flags_out    (flags_c[i+1]),
      .hit_idx_out  (hit_c[i+1]),
      .free_idx_out (free_c[i+1]),
      .last_out     (last_c[i+1]),
      .avg_out      (avg_c[i+1]),
      .wb           (wb),
      .wb_idx       (res_idx),
      .wb_id        (req_id),
      .wb_time      (req_ts),
      .wb_avg       (res_avg)
    );
  end

  // Average update unit, fed straight from the end of the row.
  sie_ewma u_ewma (
    .clk    (clk),
    .rst    (rst),
    .start  (ew_start),
    .ts     (req_ts),
    .last   (last_c[TABLE_ENTRIES]),
    .avg    (avg_c[TABLE_ENTRIES]),
    .done   (ew_done),
    .result (ew_result)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && cmd != CMD_NONE) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (cnt == CNT_LAST) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (is_event && flags_c[TABLE_ENTRIES].hit) state_next = S_CALC;
        else state_next = S_RESP;
      end
      S_CALC: begin
        if (ew_done) state_next = S_RESP;
      end
      S_RESP: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall = 1'b1;
    ew_start = 1'b0;
    wb       = '0;
    unique case (state)
      S_IDLE:   in_stall = 1'b0;
      S_SCAN:   ;
      S_DECIDE: ew_start = is_event && flags_c[TABLE_ENTRIES].hit;
      S_CALC:   ;
      S_RESP: begin
        if (slot_free) wb = res_wb;
      end
      default:  ;
    endcase
  end

  // Request capture, scan count and result decision.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      cnt     <= '0;
      req_cmd <= cmd;
      req_id  <= stream_id;
      req_ts  <= timestamp;
    end else if (state == S_SCAN) begin
      cnt <= cnt + 1'b1;
    end
    if (state == S_DECIDE) begin
      res_avg <= '0;
      if (!is_event) begin
        res_status <= ST_RELEASED;
        res_wb     <= '{ins: 1'b0, clr: flags_c[TABLE_ENTRIES].hit, upd: 1'b0};
        res_idx    <= hit_c[TABLE_ENTRIES];
      end else if (flags_c[TABLE_ENTRIES].hit) begin
        res_status <= ST_UPDATED;
        res_wb     <= '{ins: 1'b0, clr: 1'b0, upd: 1'b1};
        res_idx    <= hit_c[TABLE_ENTRIES];
      end else if (flags_c[TABLE_ENTRIES].free_found) begin
        res_status <= ST_INSERTED;
        res_wb     <= '{ins: 1'b1, clr: 1'b0, upd: 1'b0};
        res_idx    <= free_c[TABLE_ENTRIES];
      end else begin
        res_status <= ST_FULL;
        res_wb     <= '0;
        res_idx    <= hit_c[TABLE_ENTRIES];
      end
    end
    if (state == S_CALC && ew_done) begin
      res_avg <= ew_result;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && slot_free) begin
      average_interval <= res_avg;
      status           <= res_status;
    end
  end

  // Checks on the controller.
  `SIE_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && state == S_IDLE, "reset did not idle")
  `SIE_ASSERT(a_event_scans, in_valid && !in_stall && cmd != CMD_NONE |=> state == S_SCAN, "no scan")
  `SIE_ASSERT(a_result_from_resp, $rose(out_valid) |-> $past(state) == S_RESP, "stray result")
  `SIE_ASSERT(a_done_in_calc, ew_done |-> state == S_CALC, "average done outside calc")
  `SIE_ASSERT(a_update_after_calc,
    state == S_RESP && $past(state) != S_RESP && res_status == ST_UPDATED
      |-> $past(state) == S_CALC, "update skipped average unit")

endmodule

`default_nettype wire
